// ===== hw/rtl/ptt_pkg.sv =====
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int TASKS_DEF   = 16;
    localparam int ID_BITS_DEF = 16;
    localparam int MAX_RESULTS = 16;

    localparam logic [1:0] MODE_ADD     = 2'd0;
    localparam logic [1:0] MODE_ONESHOT = 2'd1;
    localparam logic [1:0] MODE_CANCEL  = 2'd2;
    localparam logic [1:0] MODE_FLUSH   = 2'd3;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_FIRED     = 3'd4;
    localparam logic [2:0] KIND_NONE      = 3'd5;

    // per-cycle command to one cell
    typedef struct packed {
        logic        step;      // shift/visit one entry this cycle
        logic        append;    // write the new entry into the tail cell
    } cell_ctl_t;

endpackage

// ===== hw/rtl/ptt_cell.sv =====
`timescale 1ns / 1ps

// One table slot. On a step, the slot takes its right neighbor's entry, so
// the table rotates one position per unstalled cycle. Cell 0 hands its entry
// to the controller, which returns it (updated) or drops it at the tail.
module ptt_cell #(
    parameter int ID_BITS = ptt_pkg::ID_BITS_DEF
) (
    input  logic                clk,
    input  ptt_pkg::cell_ctl_t  ctl,
    input  logic [ID_BITS-1:0]  in_id,
    input  logic [31:0]         in_ivl,
    input  logic [31:0]         in_ela,
    input  logic [31:0]         in_seen,
    output logic [ID_BITS-1:0]  id,
    output logic [31:0]         ivl,
    output logic [31:0]         ela,
    output logic [31:0]         seen
);

    logic [ID_BITS-1:0] id_reg;
    logic [31:0]        ivl_reg, ela_reg, seen_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.step || ctl.append)
        begin
            id_reg   <= in_id;
            ivl_reg  <= in_ivl;
            ela_reg  <= in_ela;
            seen_reg <= in_seen;
        end
    end

    assign id   = id_reg;
    assign ivl  = ivl_reg;
    assign ela  = ela_reg;
    assign seen = seen_reg;

endmodule

// ===== hw/rtl/periodic_task_table.sv =====
`timescale 1ns / 1ps
// Add: result register loaded on accept; one add item per cycle if not stalled.
// Cancel and flush visit each stored entry once at the head cell, one per cycle
// when not held; the final result is registered in S_OUT after the walk ends.
// A fired result waiting on a stalled output holds the walk; the next item is
// accepted once the walk ends and the output register is free.
// Reset (rst_n low, async) empties the table and clears the id counter.
module periodic_task_table #(
    parameter int TASKS   = ptt_pkg::TASKS_DEF,
    parameter int ID_BITS = ptt_pkg::ID_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] interval,
    input  logic [15:0] target_id,
    input  logic [31:0] now_ticks,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [15:0] task_id,
    output logic        last
);

    localparam int CW = $clog2(TASKS + 1);
    localparam int PW = $clog2(TASKS);
    localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_OUT} state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      pos_reg;      // entries visited so far
    logic [CW-1:0]      kept_reg;     // entries returned to the chain
    logic [ID_BITS-1:0] next_id_reg;
    logic [1:0]         op_reg;
    logic [15:0]        tgt_reg;
    logic [31:0]        now_reg;
    logic               hit_reg;      // cancel matched / flush fired any
    logic [4:0]         nrep_reg;     // results reported this flush
    logic               pend_reg;     // a fired result waits for its successor
    logic [15:0]        pend_id_reg;
    logic               out_valid_reg;
    logic [2:0]         kind_reg;
    logic [15:0]        tid_reg;
    logic               last_reg;

    ptt_pkg::cell_ctl_t ctl [TASKS];
    logic [ID_BITS-1:0] c_id [TASKS];
    logic [31:0]        c_ivl [TASKS], c_ela [TASKS], c_seen [TASKS];
    logic [ID_BITS-1:0] t_id;
    logic [31:0]        t_ivl, t_ela, t_seen;

    // head entry evaluation
    logic        walking, visit, done_walk, drop, fire, head_match;
    logic [31:0] delta, sum;
    logic        carry;
    logic        tail_wr;
    logic        out_load;
    logic [PW-1:0] tail_pos;
    logic [ID_BITS-1:0] new_id;

    assign new_id = (next_id_reg == ID_MAX) ? {{(ID_BITS-1){1'b0}}, 1'b1}
                                            : next_id_reg + 1'b1;
    assign {carry, sum} = {1'b0, c_ela[0]} + {1'b0, delta};
    assign delta    = now_reg - c_seen[0];
    assign walking  = (state_reg == S_WALK);
    assign done_walk = (pos_reg == count_reg);
    assign head_match = (16'(c_id[0]) == tgt_reg) && (tgt_reg != 16'd0)
                        && ((ID_BITS <= 16) || (c_id[0] >> 16) == '0);
    assign fire    = (op_reg == ptt_pkg::MODE_FLUSH) &&
                     (c_ivl[0] == 32'd0 || carry || sum >= c_ivl[0]);
    assign drop    = (op_reg == ptt_pkg::MODE_FLUSH) ? (c_ivl[0] == 32'd0)
                                                     : (head_match && !hit_reg);
    // a fired result behind a pending one needs the output register
    assign visit   = walking && !done_walk &&
                     !(fire && nrep_reg < 5'(ptt_pkg::MAX_RESULTS) && pend_reg &&
                       out_valid_reg && out_stall);
    // the kept entry goes behind the entries already kept; drops shorten the chain
    assign tail_wr  = visit && !drop;
    assign tail_pos = PW'(count_reg - (pos_reg - kept_reg) - 1'b1);

    always_comb
    begin
        t_id = c_id[0];
        t_ivl = c_ivl[0];
        t_ela = c_ela[0];
        t_seen = c_seen[0];
        if (state_reg == S_IDLE)
        begin
            t_id   = new_id;
            t_ivl  = (mode == ptt_pkg::MODE_ONESHOT) ? 32'd0 : interval;
            t_ela  = 32'd0;
            t_seen = now_ticks;
        end
        else if (op_reg == ptt_pkg::MODE_FLUSH)
        begin
            t_seen = now_reg;
            t_ela  = fire ? 32'd0 : (carry ? 32'hFFFF_FFFF : sum);
        end
    end

    logic do_add;
    assign do_add = (state_reg == S_IDLE) && in_valid && !in_stall &&
                    (mode == ptt_pkg::MODE_ADD || mode == ptt_pkg::MODE_ONESHOT) &&
                    (count_reg != CW'(TASKS));

    // output register takes a new result this cycle
    assign out_load = ((state_reg == S_IDLE) && in_valid && !in_stall &&
                       (mode == ptt_pkg::MODE_ADD || mode == ptt_pkg::MODE_ONESHOT)) ||
                      (visit && fire && nrep_reg < 5'(ptt_pkg::MAX_RESULTS) && pend_reg) ||
                      ((state_reg == S_OUT) && !(out_valid_reg && out_stall));

    // chain: each cell but the last shifts left on a visit; the tail slot
    // takes the returned entry, a dropped entry leaves a hole beyond count
    genvar g;
    generate
        for (g = 0; g < TASKS; g++)
        begin : g_cell
            logic sel_tail;
            always_comb
            begin
                sel_tail = do_add ? (PW'(count_reg) == PW'(g))
                                  : (tail_wr && tail_pos == PW'(g));
                ctl[g].step   = visit && (g < TASKS - 1) && !sel_tail;
                ctl[g].append = sel_tail;
            end
            if (g < TASKS - 1)
            begin : g_mid
                ptt_cell #(.ID_BITS(ID_BITS)) u_cell (
                    .clk(clk), .ctl(ctl[g]),
                    .in_id(sel_tail ? t_id : c_id[g+1]),
                    .in_ivl(sel_tail ? t_ivl : c_ivl[g+1]),
                    .in_ela(sel_tail ? t_ela : c_ela[g+1]),
                    .in_seen(sel_tail ? t_seen : c_seen[g+1]),
                    .id(c_id[g]), .ivl(c_ivl[g]), .ela(c_ela[g]), .seen(c_seen[g]));
            end
            else
            begin : g_end
                ptt_cell #(.ID_BITS(ID_BITS)) u_cell (
                    .clk(clk), .ctl(ctl[g]),
                    .in_id(t_id), .in_ivl(t_ivl), .in_ela(t_ela), .in_seen(t_seen),
                    .id(c_id[g]), .ivl(c_ivl[g]), .ela(c_ela[g]), .seen(c_seen[g]));
            end
        end
    endgenerate

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign task_id   = tid_reg;
    assign last      = last_reg;

    // control and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            kept_reg      <= '0;
            next_id_reg   <= '0;
            hit_reg       <= 1'b0;
            nrep_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_id_reg   <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= ptt_pkg::MODE_ADD;
            tgt_reg       <= '0;
            now_reg       <= '0;
            kind_reg      <= '0;
            tid_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        op_reg   <= mode;
                        tgt_reg  <= target_id;
                        now_reg  <= now_ticks;
                        pos_reg  <= '0;
                        kept_reg <= '0;
                        hit_reg  <= 1'b0;
                        nrep_reg <= '0;
                        pend_reg <= 1'b0;
                        if (mode == ptt_pkg::MODE_CANCEL || mode == ptt_pkg::MODE_FLUSH)
                            state_reg <= S_WALK;
                        else
                        begin
                            last_reg <= 1'b1;
                            if (count_reg == CW'(TASKS))
                            begin
                                kind_reg <= ptt_pkg::KIND_FULL;
                                tid_reg  <= '0;
                            end
                            else
                            begin
                                kind_reg    <= ptt_pkg::KIND_ADDED;
                                tid_reg     <= 16'(new_id);
                                next_id_reg <= new_id;
                                count_reg   <= count_reg + 1'b1;
                            end
                        end
                    end
                end
                S_WALK:
                begin
                    if (done_walk)
                        state_reg <= S_OUT;
                    else if (visit)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                        if (!drop)
                            kept_reg <= kept_reg + 1'b1;
                        if (op_reg == ptt_pkg::MODE_CANCEL && drop)
                        begin
                            hit_reg <= 1'b1;
                            tid_reg <= 16'(c_id[0]);
                        end
                        if (fire)
                        begin
                            hit_reg <= 1'b1;
                            if (nrep_reg < 5'(ptt_pkg::MAX_RESULTS))
                            begin
                                // hold this one; send the one held before
                                nrep_reg    <= nrep_reg + 1'b1;
                                pend_reg    <= 1'b1;
                                pend_id_reg <= 16'(c_id[0]);
                                if (pend_reg)
                                begin
                                    kind_reg <= ptt_pkg::KIND_FIRED;
                                    tid_reg  <= pend_id_reg;
                                    last_reg <= 1'b0;
                                end
                            end
                        end
                    end
                end
                S_OUT:
                begin
                    // close up: count becomes kept entries; emit final result
                    if (!(out_valid_reg && out_stall))
                    begin
                        count_reg <= kept_reg;
                        state_reg <= S_IDLE;
                        last_reg  <= 1'b1;
                        if (op_reg == ptt_pkg::MODE_CANCEL)
                        begin
                            kind_reg <= hit_reg ? ptt_pkg::KIND_CANCELLED
                                                : ptt_pkg::KIND_NOT_FOUND;
                            if (!hit_reg)
                                tid_reg <= '0;
                        end
                        else if (!hit_reg)
                        begin
                            kind_reg <= ptt_pkg::KIND_NONE;
                            tid_reg  <= '0;
                        end
                        else
                        begin
                            // the held fired result is the final one
                            kind_reg <= ptt_pkg::KIND_FIRED;
                            tid_reg  <= pend_id_reg;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TASKS)) else $error("entry count above capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        walking |-> pos_reg <= count_reg) else $error("walk overran table");
    assert property (@(posedge clk) disable iff (!rst_n)
        walking |-> kept_reg <= pos_reg) else $error("kept count above visited");

endmodule

// ===== dv/periodic_task_table_test.sv =====
`timescale 1ns / 1ps

module periodic_task_table_test;

    localparam int NUM_TASKS = 16;
    localparam int LIMIT_CYCLES = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [31:0] interval;
    logic [15:0] target_id;
    logic [31:0] now_ticks;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [15:0] task_id;
    logic        last;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] id;
        logic        last;
    } timer_event_t;

    // predicted table
    logic [15:0] tbl_id[NUM_TASKS];
    logic [31:0] tbl_period[NUM_TASKS];
    logic [31:0] tbl_accum[NUM_TASKS];
    logic [31:0] tbl_seen[NUM_TASKS];
    int          tbl_count;
    logic [15:0] id_counter;

    timer_event_t pending_events[$];
    int  mismatches;
    int  cycle_count;
    bit  stall_enable;
    bit  gap_enable;
    logic [31:0] tick_clock;

    periodic_task_table dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .interval(interval), .target_id(target_id),
        .now_ticks(now_ticks),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .task_id(task_id), .last(last)
    );

    always #2 clk = ~clk;

    function automatic timer_event_t mk(logic [2:0] k, logic [15:0] id, logic l);
        timer_event_t e;
        e.kind = k;
        e.id = id;
        e.last = l;
        return e;
    endfunction

    function automatic void drop_entry(int pos);
        for (int i = pos; i < tbl_count - 1; i++)
        begin
            tbl_id[i] = tbl_id[i + 1];
            tbl_period[i] = tbl_period[i + 1];
            tbl_accum[i] = tbl_accum[i + 1];
            tbl_seen[i] = tbl_seen[i + 1];
        end
        tbl_count--;
    endfunction

    // predicted results of one item, queued in order
    function automatic void predict_events(logic [1:0] m, logic [31:0] per,
                                           logic [15:0] tgt, logic [31:0] now);
        int i;
        int n;
        int pos;
        logic [15:0] id;
        logic [32:0] sum;
        logic [31:0] sat;
        bit fire;
        if (m == ptt_pkg::MODE_ADD || m == ptt_pkg::MODE_ONESHOT)
        begin
            if (tbl_count >= NUM_TASKS)
                pending_events.push_back(mk(ptt_pkg::KIND_FULL, 16'd0, 1'b1));
            else
            begin
                id_counter = (id_counter == 16'hFFFF) ? 16'd1 : id_counter + 16'd1;
                tbl_id[tbl_count] = id_counter;
                tbl_period[tbl_count] = (m == ptt_pkg::MODE_ONESHOT) ? 32'd0 : per;
                tbl_accum[tbl_count] = 32'd0;
                tbl_seen[tbl_count] = now;
                tbl_count++;
                pending_events.push_back(mk(ptt_pkg::KIND_ADDED, id_counter, 1'b1));
            end
        end
        else if (m == ptt_pkg::MODE_CANCEL)
        begin
            pos = -1;
            for (i = 0; i < tbl_count; i++)
                if (pos < 0 && tgt != 0 && tbl_id[i] == tgt)
                    pos = i;
            if (pos >= 0)
            begin
                drop_entry(pos);
                pending_events.push_back(mk(ptt_pkg::KIND_CANCELLED, tgt, 1'b1));
            end
            else
                pending_events.push_back(mk(ptt_pkg::KIND_NOT_FOUND, 16'd0, 1'b1));
        end
        else
        begin
            n = 0;
            i = 0;
            while (i < tbl_count)
            begin
                id = tbl_id[i];
                if (tbl_period[i] == 0)
                begin
                    drop_entry(i);
                    fire = 1;
                end
                else
                begin
                    sum = {1'b0, tbl_accum[i]} + {1'b0, now - tbl_seen[i]};
                    sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    tbl_seen[i] = now;
                    fire = sat >= tbl_period[i];
                    tbl_accum[i] = fire ? 32'd0 : sat;
                    i++;
                end
                if (fire && n < ptt_pkg::MAX_RESULTS)
                begin
                    pending_events.push_back(mk(ptt_pkg::KIND_FIRED, id, 1'b0));
                    n++;
                end
            end
            if (n == 0)
                pending_events.push_back(mk(ptt_pkg::KIND_NONE, 16'd0, 1'b1));
            else
                pending_events[$].last = 1'b1;
        end
    endfunction

    // send one item; random gap first; valid stays up until the next item or drain
    task automatic send_item(logic [1:0] m, logic [31:0] per, logic [15:0] tgt,
                             logic [31:0] now);
        int gap;
        if (gap_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predict_events(m, per, tgt, now);
        in_valid <= 1'b1;
        mode <= m;
        interval <= per;
        target_id <= tgt;
        now_ticks <= now;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        timer_event_t exp_ev;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d id=%0d last=%0d",
                             kind, task_id, last);
            end
            else
            begin
                exp_ev = pending_events.pop_front();
                if (kind !== exp_ev.kind || task_id !== exp_ev.id ||
                    last !== exp_ev.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected kind=%0d id=%0d last=%0d,",
                                  " got kind=%0d id=%0d last=%0d"},
                                 exp_ev.kind, exp_ev.id, exp_ev.last,
                                 kind, task_id, last);
                end
            end
        end
    end

    // receiver stall bursts
    initial
    begin
        int burst;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_enable && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [31:0] rand32();
        return $urandom();
    endfunction

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (NUM_TASKS + 4) @(posedge clk);
    endtask

    task automatic test_directed();
        // empty flush, unknown cancels, zero id
        send_item(ptt_pkg::MODE_FLUSH, 32'd0, 16'd0, 32'd0);
        send_item(ptt_pkg::MODE_CANCEL, 32'd0, 16'd0, 32'd0);
        send_item(ptt_pkg::MODE_CANCEL, 32'd0, 16'hFFFF, 32'd0);
        // one-shot ignores interval, repeating, extreme intervals
        send_item(ptt_pkg::MODE_ONESHOT, 32'hFFFF_FFFF, 16'd0, 32'hFFFF_FFFF);
        send_item(ptt_pkg::MODE_ADD, 32'd0, 16'd0, 32'd10);
        send_item(ptt_pkg::MODE_ADD, 32'd5, 16'd0, 32'hFFFF_FFFE);
        send_item(ptt_pkg::MODE_ADD, 32'hFFFF_FFFF, 16'd0, 32'd0);
        send_item(ptt_pkg::MODE_ADD, 32'd1, 16'd0, 32'd0);
        // wrap of tick time, then saturate the big one
        send_item(ptt_pkg::MODE_FLUSH, 32'd0, 16'd0, 32'd4);
        send_item(ptt_pkg::MODE_FLUSH, 32'd0, 16'd0, 32'hFFFF_FFFF);
        send_item(ptt_pkg::MODE_FLUSH, 32'd0, 16'd0, 32'hFFFF_FFFE);
        send_item(ptt_pkg::MODE_CANCEL, 32'd0, 16'd3, 32'd0);
        send_item(ptt_pkg::MODE_CANCEL, 32'd0, 16'd3, 32'd0);
        // fill to full and overflow
        for (int i = 0; i < NUM_TASKS + 1; i++)
            send_item(i[0] ? ptt_pkg::MODE_ONESHOT : ptt_pkg::MODE_ADD,
                      32'd1, 16'd0, 32'd0);
        send_item(ptt_pkg::MODE_FLUSH, 32'd0, 16'd0, 32'd7);
        wait_drain();
    endtask

    task automatic test_random(int count);
        int r;
        logic [15:0] tgt;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 9);
            tick_clock = tick_clock + $urandom_range(0, 40);
            if ($urandom_range(0, 19) == 0)
                tick_clock = rand32();
            if (r < 4)
                send_item(r[0] ? ptt_pkg::MODE_ONESHOT : ptt_pkg::MODE_ADD,
                          ($urandom_range(0, 3) == 0) ? rand32() : $urandom_range(0, 60),
                          16'(rand32()), tick_clock);
            else if (r < 6)
            begin
                if (tbl_count > 0 && $urandom_range(0, 3) != 0)
                    tgt = tbl_id[$urandom_range(0, tbl_count - 1)];
                else
                    tgt = 16'(rand32());
                send_item(ptt_pkg::MODE_CANCEL, rand32(), tgt, rand32());
            end
            else
                send_item(ptt_pkg::MODE_FLUSH, rand32(), 16'(rand32()), tick_clock);
        end
        wait_drain();
    endtask

    // back-to-back cancel of the head and one-shot adds
    task automatic test_churn();
        for (int i = 0; i < 10; i++)
        begin
            if (tbl_count > 0)
                send_item(ptt_pkg::MODE_CANCEL, 32'd0, tbl_id[0], 32'd0);
            send_item(ptt_pkg::MODE_ONESHOT, 32'd0, 16'd0, 32'd0);
        end
        send_item(ptt_pkg::MODE_FLUSH, 32'd0, 16'd0, 32'd0);
        wait_drain();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = ptt_pkg::MODE_ADD;
        interval = 32'd0;
        target_id = 16'd0;
        now_ticks = 32'd0;
        tbl_count = 0;
        id_counter = 16'd0;
        tick_clock = 32'd0;
        stall_enable = 1'b1;
        gap_enable = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(130);
        stall_enable = 1'b0;
        gap_enable = 1'b0;
        test_churn();
        test_random(30);
        if (mismatches == 0 && pending_events.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
